// File: sv/ndbc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the oscillator down-converter
// and its boxcar cascade. No dependencies.
package ndbc_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [1:0] REG_DECIMATION = 2'd1;
    localparam logic [1:0] REG_WINDOW_LEN = 2'd2;
    localparam logic [1:0] REG_INV_LEN    = 2'd3;

    localparam int SUM_W  = 27;
    localparam int WIDE_W = 48;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    // per-cell control, driven by the sequencer in the top level
    typedef struct packed {
        logic rd_en;   // fetch oldest entries
        logic old_ok;  // fetched entry was written since reset
        logic sum_en;  // update running sums and write the ring
        logic out_en;  // scale, round and saturate the sums
    } t_cell_ctl;

    // saturate a wide signed value to Q1.15
    function automatic logic signed [15:0] sat_q15(input logic signed [WIDE_W-1:0] v);
        logic signed [15:0] r;
        if (v > 48'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -48'sd32768) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // sin(k*(pi/2)/2^qbits) in Q1.15, evaluated at elaboration for the table
    function automatic logic [15:0] quarter_sine(input longint unsigned k,
                                                 input int qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (k * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[15:0];
    endfunction

endpackage

// File: sv/ndbc_cell.sv
`timescale 1ns / 1ps
// One boxcar stage for the I and Q lines: two delay rings and running sums.
// Depends on ndbc_pkg.
module ndbc_cell #(
    parameter int MAX_WINDOW = 1024,
    parameter int AW         = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ndbc_pkg::t_cell_ctl  i_ctl,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [15:0]          i_inv_len,
    input  logic signed [15:0]   i_in_i,
    input  logic signed [15:0]   i_in_q,
    output logic signed [15:0]   o_out_i,
    output logic signed [15:0]   o_out_q
);

    logic signed [15:0] r_mem_i [MAX_WINDOW];
    logic signed [15:0] r_mem_q [MAX_WINDOW];
    logic signed [15:0] r_old_i;
    logic signed [15:0] r_old_q;
    logic               r_old_ok;
    logic signed [ndbc_pkg::SUM_W-1:0] r_sum_i;
    logic signed [ndbc_pkg::SUM_W-1:0] r_sum_q;
    logic signed [15:0] r_out_i;
    logic signed [15:0] r_out_q;

    logic signed [15:0] w_old_i;
    logic signed [15:0] w_old_q;
    logic signed [ndbc_pkg::SUM_W-1:0] n_sum_i;
    logic signed [ndbc_pkg::SUM_W-1:0] n_sum_q;
    logic signed [43:0] w_prod_i;
    logic signed [43:0] w_prod_q;
    logic signed [27:0] w_rnd_i;
    logic signed [27:0] w_rnd_q;

    // ring storage: read oldest, write newest
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_old_i <= r_mem_i[i_rd_addr];
            r_old_q <= r_mem_q[i_rd_addr];
            r_old_ok <= i_ctl.old_ok;
        end
        if (i_ctl.sum_en) begin
            r_mem_i[i_wr_addr] <= i_in_i;
            r_mem_q[i_wr_addr] <= i_in_q;
        end
    end

    // unwritten entries read as zero
    assign w_old_i = r_old_ok ? r_old_i : 16'sd0;
    assign w_old_q = r_old_ok ? r_old_q : 16'sd0;

    // running sums wrap at their width
    assign n_sum_i = r_sum_i + ndbc_pkg::SUM_W'(i_in_i) - ndbc_pkg::SUM_W'(w_old_i);
    assign n_sum_q = r_sum_q + ndbc_pkg::SUM_W'(i_in_q) - ndbc_pkg::SUM_W'(w_old_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_i <= '0;
            r_sum_q <= '0;
        end else if (i_ctl.sum_en) begin
            r_sum_i <= n_sum_i;
            r_sum_q <= n_sum_q;
        end
    end

    // scale by the reciprocal, round half up, saturate
    assign w_prod_i = r_sum_i * $signed({1'b0, i_inv_len});
    assign w_prod_q = r_sum_q * $signed({1'b0, i_inv_len});
    assign w_rnd_i  = 28'((w_prod_i + 44'sd32768) >>> 16);
    assign w_rnd_q  = 28'((w_prod_q + 44'sd32768) >>> 16);

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_en) begin
            r_out_i <= ndbc_pkg::sat_q15(ndbc_pkg::WIDE_W'(w_rnd_i));
            r_out_q <= ndbc_pkg::sat_q15(ndbc_pkg::WIDE_W'(w_rnd_q));
        end
    end

    assign o_out_i = r_out_i;
    assign o_out_q = r_out_q;

endmodule

// File: sv/nco_downconvert_boxcar_cascade.sv
`timescale 1ns / 1ps
// Oscillator mixer, chain of boxcar cells and decimator.
// Depends on ndbc_pkg and ndbc_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------
//  input   | i_valid / o_stall    | i_sample
//  output  | o_valid / i_stall    | o_out_i, o_out_q
//  config  | i_cfg_wr_en          | i_cfg_index, i_cfg_data
//
// An item passes through steps in order: take the beat and look up the
// sine, mix, then sum and scale in each cell, and hand over the result;
// the cells work one after another; no new beat is taken before the hand-over.
// A pending result held by o_valid with i_stall high delays the hand-over.
// Reset clears control and sums; rings are masked by a fill flag, no sweep.
module nco_downconvert_boxcar_cascade #(
    parameter int MAX_WINDOW      = 1024,
    parameter int NUM_STAGES      = 4,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_i,
    output logic signed [15:0] o_out_q,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int TB  = SINE_TABLE_BITS;
    localparam int QB  = SINE_TABLE_BITS - 2;
    localparam int QN  = 2 ** QB;
    localparam int TOK = 2 * NUM_STAGES + 1;

    // configuration
    logic [31:0] r_phase_step;
    logic [15:0] r_decimation;
    logic [10:0] r_window_len;
    logic [15:0] r_inv_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_decimation <= 16'd1;
            r_window_len <= 11'd1024;
            r_inv_len    <= 16'd64;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ndbc_pkg::REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                ndbc_pkg::REG_DECIMATION: r_decimation <= i_cfg_data[15:0];
                ndbc_pkg::REG_WINDOW_LEN: r_window_len <= i_cfg_data[10:0];
                ndbc_pkg::REG_INV_LEN:    r_inv_len    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // quarter-wave sine table, built at elaboration
    logic [15:0] w_rom [QN+1];
    for (genvar g = 0; g <= QN; g++) begin : g_rom
        assign w_rom[g] = ndbc_pkg::quarter_sine(64'(g), QB);
    end

    logic [31:0]        r_phase;
    logic [TB-1:0]      w_sidx;
    logic [TB-1:0]      w_cidx;
    logic [QB:0]        w_sk;
    logic [QB:0]        w_ck;
    logic signed [15:0] w_sin;
    logic signed [15:0] w_cos;

    assign w_sidx = r_phase[31 -: TB];
    assign w_cidx = w_sidx + TB'(QN);

    // fold each index into the first quadrant and restore the sign
    always_comb begin
        w_sk = {1'b0, w_sidx[QB-1:0]};
        w_ck = {1'b0, w_cidx[QB-1:0]};
        if (w_sidx[QB]) begin
            w_sk = (QB+1)'(QN) - w_sk;
        end
        if (w_cidx[QB]) begin
            w_ck = (QB+1)'(QN) - w_ck;
        end
        w_sin = w_sidx[TB-1] ? -$signed(w_rom[w_sk]) : $signed(w_rom[w_sk]);
        w_cos = w_cidx[TB-1] ? -$signed(w_rom[w_ck]) : $signed(w_rom[w_ck]);
    end

    // sequencer state
    logic           r_busy;
    logic [TOK-1:0] r_tok;
    logic           r_done;
    logic           r_emit;
    logic [15:0]    r_decim_cnt;
    logic [AW-1:0]  r_ring;
    logic           r_full;
    logic           r_ovalid;
    logic           w_in_acc;
    logic           w_out_free;
    logic           w_finish;

    assign o_stall    = r_busy;
    assign w_in_acc   = i_valid && !r_busy;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_finish   = r_done && (!r_emit || w_out_free);

    // oldest position: window length behind the ring index
    logic [16:0]   w_len17;
    logic [AW:0]   w_len;
    logic [AW:0]   w_old_sum;
    logic [AW-1:0] w_oldpos;
    logic          w_old_ok;

    always_comb begin
        w_len17 = 17'(r_window_len);
        if (w_len17 == 17'd0) begin
            w_len17 = 17'd1;
        end
        if (w_len17 > 17'(MAX_WINDOW)) begin
            w_len17 = 17'(MAX_WINDOW);
        end
        w_len     = (AW+1)'(w_len17);
        w_old_sum = {1'b0, r_ring} + (AW+1)'(MAX_WINDOW) - w_len;
        if (w_old_sum >= (AW+1)'(MAX_WINDOW)) begin
            w_old_sum = w_old_sum - (AW+1)'(MAX_WINDOW);
        end
        w_oldpos = w_old_sum[AW-1:0];
        w_old_ok = r_full || (w_oldpos < r_ring);
    end

    // decimation count
    logic [15:0] w_dec;
    logic [16:0] w_dec_nxt;
    assign w_dec     = (r_decimation == 16'd0) ? 16'd1 : r_decimation;
    assign w_dec_nxt = {1'b0, r_decim_cnt} + 17'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tok       <= '0;
            r_done      <= 1'b0;
            r_emit      <= 1'b0;
            r_decim_cnt <= '0;
            r_ring      <= '0;
            r_full      <= 1'b0;
            r_phase     <= '0;
        end else begin
            r_tok  <= {r_tok[TOK-2:0], w_in_acc};
            if (r_tok[TOK-1]) begin
                r_done <= 1'b1;
            end
            // take a beat: advance phase and decimation count
            if (w_in_acc) begin
                r_busy      <= 1'b1;
                r_phase     <= r_phase + r_phase_step;
                r_emit      <= (r_decim_cnt == 16'd0);
                r_decim_cnt <= (w_dec_nxt >= {1'b0, w_dec}) ? 16'd0 : w_dec_nxt[15:0];
            end
            // hand over and advance the ring
            if (w_finish) begin
                r_done <= 1'b0;
                r_busy <= 1'b0;
                if (r_ring == AW'(MAX_WINDOW - 1)) begin
                    r_ring <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_ring <= r_ring + AW'(1);
                end
            end
        end
    end

    // hold the sample and oscillator values for the mixer
    logic signed [15:0] r_smp;
    logic signed [15:0] r_sin;
    logic signed [15:0] r_cos;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_smp <= i_sample;
            r_sin <= w_sin;
            r_cos <= w_cos;
        end
    end

    // mixer: I = x*cos, Q = -x*sin
    logic signed [32:0] w_pi;
    logic signed [32:0] w_pq;
    logic signed [17:0] w_ri;
    logic signed [17:0] w_rq;
    logic signed [15:0] r_mix_i;
    logic signed [15:0] r_mix_q;

    assign w_pi = 33'(r_smp * r_cos);
    assign w_pq = -33'(r_smp * r_sin);
    assign w_ri = 18'((w_pi + 33'sd16384) >>> 15);
    assign w_rq = 18'((w_pq + 33'sd16384) >>> 15);

    always_ff @(posedge i_clk) begin
        if (r_tok[0]) begin
            r_mix_i <= ndbc_pkg::sat_q15(ndbc_pkg::WIDE_W'(w_ri));
            r_mix_q <= ndbc_pkg::sat_q15(ndbc_pkg::WIDE_W'(w_rq));
        end
    end

    // chain of stage cells
    logic signed [15:0] w_ci [NUM_STAGES+1];
    logic signed [15:0] w_cq [NUM_STAGES+1];
    assign w_ci[0] = r_mix_i;
    assign w_cq[0] = r_mix_q;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_cell
        ndbc_pkg::t_cell_ctl w_ctl;
        assign w_ctl.rd_en  = w_in_acc;
        assign w_ctl.old_ok = w_old_ok;
        assign w_ctl.sum_en = r_tok[2*s+1];
        assign w_ctl.out_en = r_tok[2*s+2];

        ndbc_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .AW         (AW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_rd_addr (w_oldpos),
            .i_wr_addr (r_ring),
            .i_inv_len (r_inv_len),
            .i_in_i    (w_ci[s]),
            .i_in_q    (w_cq[s]),
            .o_out_i   (w_ci[s+1]),
            .o_out_q   (w_cq[s+1])
        );
    end

    // output register
    logic signed [15:0] r_oi;
    logic signed [15:0] r_oq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_finish && r_emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish && r_emit) begin
            r_oi <= w_ci[NUM_STAGES];
            r_oq <= w_cq[NUM_STAGES];
        end
    end

    assign o_valid = r_ovalid;
    assign o_out_i = r_oi;
    assign o_out_q = r_oq;

    // at most one step of an item is active
    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_tok, r_done}))
        else $error("sequencer token not one-hot");

    // a token in flight implies a busy block
    a_tok_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tok != '0 || r_done) |-> r_busy)
        else $error("item in flight while idle");

    // a result blocked by a full output register waits
    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_emit && r_ovalid && i_stall) |=> r_done)
        else $error("result dropped under stall");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for nco_downconvert_boxcar_cascade: a queue-fed driver,
// a result monitor and a bit-exact predictor of mixer, boxcars and decimator.
// Depends on ndbc_pkg and the block's RTL.
module testbench;

    localparam int RING_DEPTH = 1024;
    localparam int STAGES     = 4;
    localparam int LINES      = STAGES * 2;
    localparam int TBL_BITS   = 10;
    localparam int CYCLE_LIMIT = 2000000;
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned UNIT_Q30         = 64'd1073741824;

    typedef struct {
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
    } t_iq;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_sample = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_out_i;
    logic signed [15:0] o_out_q;
    logic               i_cfg_wr_en = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    nco_downconvert_boxcar_cascade uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0]        nco_step, nco_phase;
    logic [15:0]        decim_ratio, decim_cnt;
    logic [10:0]        win_len;
    logic [15:0]        win_recip;
    logic signed [15:0] ring [LINES][RING_DEPTH];
    logic signed [26:0] run_sum [LINES];
    int                 ring_pos;

    logic signed [15:0] samples_pending [$];
    t_iq                iq_expected [$];
    int                 errors = 0;
    int                 n_samples = 0;
    int                 n_results = 0;
    bit                 no_gaps = 1'b0;
    int                 cycles = 0;

    // sin(k*(pi/2)/q) in Q1.15 by the truncated series
    function automatic longint q15_quarter_sin(longint unsigned k, longint unsigned q);
        longint unsigned x, x2, t, s;
        x  = k * QUARTER_TURN_Q30 / q;
        x2 = (x * x) >> 30;
        t  = UNIT_Q30 - x2 / 72;
        t  = UNIT_Q30 - ((x2 * t) >> 30) / 42;
        t  = UNIT_Q30 - ((x2 * t) >> 30) / 20;
        t  = UNIT_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + 16384) >> 15;
        if (s > 32767) s = 32767;
        return longint'(s);
    endfunction

    function automatic longint osc_sin(int unsigned idx);
        int unsigned q, quad, k;
        longint v;
        q    = (1 << TBL_BITS) >> 2;
        quad = (idx / q) & 3;
        k    = idx % q;
        if (quad & 1) k = q - k;
        v = q15_quarter_sin(k, q);
        return (quad >= 2) ? -v : v;
    endfunction

    function automatic logic signed [15:0] round_sat(longint v, int sh);
        longint r;
        r = (v + (longint'(1) << (sh - 1))) >>> sh;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // advance the predictor by one sample; queue the I/Q it emits, if any
    task automatic downconvert_sample(logic signed [15:0] smp);
        int unsigned idx, cidx, len, oldpos;
        longint x;
        logic signed [15:0] v [2];
        logic signed [26:0] s;
        logic [15:0] dec, nxt;
        t_iq r;
        x    = smp;
        idx  = nco_phase >> (32 - TBL_BITS);
        cidx = (idx + (1 << (TBL_BITS - 2))) & ((1 << TBL_BITS) - 1);
        v[0] = round_sat(x * osc_sin(cidx), 15);
        v[1] = round_sat(-(x * osc_sin(idx)), 15);
        nco_phase = nco_phase + nco_step;
        len = win_len;
        if (len < 1) len = 1;
        if (len > RING_DEPTH) len = RING_DEPTH;
        oldpos = (ring_pos + RING_DEPTH - len) % RING_DEPTH;
        for (int st = 0; st < STAGES; st++) begin
            for (int c = 0; c < 2; c++) begin
                s = run_sum[2*st+c] + v[c] - ring[2*st+c][oldpos];
                run_sum[2*st+c] = s;
                ring[2*st+c][ring_pos] = v[c];
                v[c] = round_sat(longint'(s) * longint'(win_recip), 16);
            end
        end
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        dec = (decim_ratio == 0) ? 16'd1 : decim_ratio;
        nxt = decim_cnt + 16'd1;
        if (decim_cnt == 0) begin
            r.i_val = v[0];
            r.q_val = v[1];
            iq_expected.push_back(r);
        end
        decim_cnt = ({1'b0, nxt} >= {1'b0, dec}) ? 16'd0 : nxt;
    endtask

    // write one register at idle and mirror it in the predictor
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            ndbc_pkg::REG_PHASE_STEP: nco_step    = val;
            ndbc_pkg::REG_DECIMATION: decim_ratio = val[15:0];
            ndbc_pkg::REG_WINDOW_LEN: win_len     = val[10:0];
            ndbc_pkg::REG_INV_LEN:    win_recip   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        wait (samples_pending.size() == 0 && !i_valid && iq_expected.size() == 0);
        repeat (25) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] stp, logic [31:0] dec, logic [31:0] wl,
                             logic [31:0] inv, int n);
        write_reg(ndbc_pkg::REG_PHASE_STEP, stp);
        write_reg(ndbc_pkg::REG_DECIMATION, dec);
        write_reg(ndbc_pkg::REG_WINDOW_LEN, wl);
        write_reg(ndbc_pkg::REG_INV_LEN, inv);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
                0:       samples_pending.push_back($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
                1:       samples_pending.push_back(16'($urandom_range(0, 63)) - 16'sd32);
                default: samples_pending.push_back(16'($urandom));
            endcase
        end
        drain();
    endtask

    // sender: one beat per item after a drawn gap
    int  send_gap = 0;
    bit  in_taken = 1'b0;
    always @(negedge i_clk) begin
        logic               nv;
        logic signed [15:0] ns;
        nv = i_valid;
        ns = i_sample;
        if (i_rst_n && (!i_valid || in_taken)) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (samples_pending.size() > 0) begin
                ns = samples_pending.pop_front();
                nv = 1'b1;
                send_gap = no_gaps ? 0 : $urandom_range(0, 19);
            end
        end
        in_taken = 1'b0;
        i_valid  <= nv;
        i_sample <= ns;
    end

    // receiver: hold stall for a drawn count after each result
    int  stall_left = 0;
    bit  out_taken = 1'b0;
    always @(negedge i_clk) begin
        if (out_taken) stall_left = no_gaps ? 0 : $urandom_range(0, 19);
        out_taken = 1'b0;
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor: predict on accepted samples, compare accepted results
    always @(posedge i_clk) begin
        t_iq e;
        if (i_rst_n && i_valid && !o_stall) begin
            in_taken = 1'b1;
            n_samples++;
            downconvert_sample(i_sample);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            out_taken = 1'b1;
            n_results++;
            if (iq_expected.size() == 0) begin
                $display("%0t: unexpected result I=%0d Q=%0d", $time, o_out_i, o_out_q);
                errors++;
            end else begin
                e = iq_expected.pop_front();
                if (o_out_i !== e.i_val) begin
                    $display("%0t: out_i expected %0d got %0d", $time, e.i_val, o_out_i);
                    errors++;
                end
                if (o_out_q !== e.q_val) begin
                    $display("%0t: out_q expected %0d got %0d", $time, e.q_val, o_out_q);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        nco_step = 0; nco_phase = 0; decim_ratio = 1; decim_cnt = 0;
        win_len = 11'd1024; win_recip = 16'd64; ring_pos = 0;
        for (int l = 0; l < LINES; l++) begin
            run_sum[l] = '0;
            for (int p = 0; p < RING_DEPTH; p++) ring[l][p] = '0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes at reset settings
        samples_pending = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1,
                            16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa};
        drain();
        // directed: saturating scale, single-tap window, full-scale steps
        write_reg(ndbc_pkg::REG_WINDOW_LEN, 32'd1);
        write_reg(ndbc_pkg::REG_INV_LEN, 32'd65535);
        write_reg(ndbc_pkg::REG_PHASE_STEP, 32'h4000_0000);
        samples_pending = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                            16'sh8000, 16'sh0001, 16'shffff, 16'sh4000, 16'shc000};
        drain();

        run_phase(32'h0400_0000, 1,     4,    16384, 120);
        run_phase(32'hffff_ffff, 7,     1,    65535, 120);
        // decimation lowered from 7 to 2, window and scale of zero
        run_phase(32'h8000_0000, 2,     0,    0,     100);
        run_phase($urandom,      3,     2047, 64,    150);
        run_phase(32'h1234_5679, 1,     16,   4096,  120);
        no_gaps = 1'b1;
        run_phase($urandom,      0,     3,    21845, 150);
        no_gaps = 1'b0;
        run_phase(32'h0100_0000, 65535, 8,    8192,  60);
        run_phase($urandom,      1,     1024, 64,    60);

        $display("covered %0d samples and %0d I/Q results over ten register settings",
                 n_samples, n_results);
        $display("including window and decimation of zero and saturating scales");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
